/* hw/rtl/bfag_pkg.sv */
`default_nettype none

package bfag_pkg;

  // Widths of the configuration fields and of the result fields
  localparam int CFG_DIM_W  = 14;
  localparam int COLOR_W    = 32;
  localparam int IDX_W      = 26;
  localparam int REG_IDX_W  = 3;
  localparam int MODE_W     = 2;

  localparam logic [COLOR_W-1:0] GREY_FALLBACK = 32'hFF333333;
  localparam logic [COLOR_W-1:0] COLOR_RESET   = 32'hAAAAAAAA;

  // Fill modes; the fourth code has no meaning and reports an error
  localparam logic [MODE_W-1:0] MODE_SOLID  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TILED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCALED = 2'd2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILL_MODE     = 3'd0,
    REG_FILL_COLOR    = 3'd1,
    REG_CANVAS_W      = 3'd2,
    REG_CANVAS_H      = 3'd3,
    REG_IMAGE_W       = 3'd4,
    REG_IMAGE_H       = 3'd5,
    REG_IMAGE_PRESENT = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START_X,
    ST_WAIT_X,
    ST_START_Y,
    ST_WAIT_Y,
    ST_ADDR,
    ST_WRITE
  } state_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  typedef struct packed {
    logic  accept;
    logic  load;
    logic  div_start;
    logic  capture;
    axis_t axis;
    logic  addr;
    logic  commit;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic fill;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/bfag_if.sv */
`default_nettype none

interface bfag_cfg_if import bfag_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface bfag_tick_if import bfag_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, restart, input ready);
  modport sink   (input valid, restart, output ready);
endinterface

interface bfag_pixel_if import bfag_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   pixel_index;
  logic [IDX_W-1:0]   source_index;
  logic               use_fill;
  logic [COLOR_W-1:0] fill_value;
  logic               status;
  logic               last;

  modport source (output valid, pixel_index, source_index, use_fill, fill_value, status,
                  last, input ready);
  modport sink   (input valid, pixel_index, source_index, use_fill, fill_value, status,
                  last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bfag_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle
module bfag_div #(
  parameter int NW = 27,
  parameter int DW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;

  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, q[NW-1]};
  assign diff   = rem_sh - {1'b0, d};
  assign ge     = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (cnt != '0) begin
      q   <= {q[NW-2:0], ge};
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quotient  = q;
  assign remainder = rem;
  assign done      = (cnt == '0);

endmodule

`default_nettype wire

/* hw/rtl/bfag_ctrl.sv */
`default_nettype none

module bfag_ctrl import bfag_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  dp_sts_t sts,
  output logic    in_ready,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.err) begin
          state_next = ST_WRITE;
        end else if (sts.fill) begin
          state_next = ST_ADDR;
        end else begin
          state_next = ST_START_X;
        end
      end
      ST_START_X: state_next = ST_WAIT_X;
      ST_WAIT_X: begin
        if (sts.div_done) state_next = ST_START_Y;
      end
      ST_START_Y: state_next = ST_WAIT_Y;
      ST_WAIT_Y: begin
        if (sts.div_done) state_next = ST_ADDR;
      end
      ST_ADDR: state_next = ST_WRITE;
      ST_WRITE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = AXIS_X;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD:    cmd.load = 1'b1;
      ST_START_X: cmd.div_start = 1'b1;
      ST_WAIT_X:  cmd.capture = sts.div_done;
      ST_START_Y: begin
        cmd.div_start = 1'b1;
        cmd.axis      = AXIS_Y;
      end
      ST_WAIT_Y: begin
        cmd.capture = sts.div_done;
        cmd.axis    = AXIS_Y;
      end
      ST_ADDR:  cmd.addr = 1'b1;
      ST_WRITE: cmd.commit = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/bfag_dp.sv */
`default_nettype none

module bfag_dp import bfag_pkg::*; #(
  parameter int MAX_DIM = 8192
) (
  input  logic   clk,
  input  logic   rst,
  bfag_cfg_if.sink     cfg,
  input  logic   restart,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  bfag_pixel_if.source pixel
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int NW = PW + DW;

  // configuration registers
  logic [MODE_W-1:0]    fill_mode;
  logic [COLOR_W-1:0]   fill_color;
  logic [CFG_DIM_W-1:0] canvas_width;
  logic [CFG_DIM_W-1:0] canvas_height;
  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic                 image_present;

  // walk state and per-pixel work registers
  logic [PW-1:0] dest_x;
  logic [PW-1:0] dest_y;
  logic [PW-1:0] dest_x_next;
  logic [PW-1:0] dest_y_next;
  logic          restart_q;
  logic [PW-1:0] cur_x;
  logic [PW-1:0] cur_y;
  logic [PW-1:0] src_x;
  logic [PW-1:0] src_y;
  logic [NW-1:0] pix_prod;
  logic [NW-1:0] src_prod;
  logic          out_valid;

  logic [DW-1:0] cw, ch, iw, ih;
  logic          image_mode;
  logic          tiled;
  logic          err;
  logic          fill;
  logic [COLOR_W-1:0] fill_val;
  logic          wrap;
  logic [DW-1:0] x_inc;
  logic [DW-1:0] y_inc;
  logic          last_px;

  logic [PW-1:0] pos_sel;
  logic [DW-1:0] isz_sel;
  logic [DW-1:0] csz_sel;
  logic [NW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic [NW-1:0] div_quot;
  logic [DW-1:0] div_rem;
  logic          div_done;
  logic [PW-1:0] coord;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v);
    return ({1'b0, v} > (CFG_DIM_W + 1)'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(v);
  endfunction

  assign cw = clamp_dim(canvas_width);
  assign ch = clamp_dim(canvas_height);
  assign iw = clamp_dim(image_width);
  assign ih = clamp_dim(image_height);

  assign image_mode = (fill_mode == MODE_TILED) || (fill_mode == MODE_SCALED);
  assign tiled      = (fill_mode == MODE_TILED);
  assign err = (cw == '0) || (ch == '0) ||
               !((fill_mode == MODE_SOLID) || image_mode) ||
               (image_mode && image_present && ((iw == '0) || (ih == '0)));
  assign fill     = (fill_mode == MODE_SOLID) || !image_present;
  assign fill_val = (fill_mode == MODE_SOLID) ? fill_color : GREY_FALLBACK;

  assign sts.err      = err;
  assign sts.fill     = fill;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || pixel.ready;

  assign cfg.ready = 1'b1;

  // restart, or a position left outside a shrunken canvas, wraps to pixel zero
  assign wrap = restart_q || (DW'(dest_x) >= cw) || (DW'(dest_y) >= ch);

  // source coordinate of one axis: modulo in tiled mode, scaled quotient otherwise
  assign pos_sel = (cmd.axis == AXIS_Y) ? cur_y : cur_x;
  assign isz_sel = (cmd.axis == AXIS_Y) ? ih : iw;
  assign csz_sel = (cmd.axis == AXIS_Y) ? ch : cw;

  assign div_dividend = tiled ? NW'(pos_sel) : NW'(pos_sel) * NW'(isz_sel);
  assign div_divisor  = tiled ? isz_sel : csz_sel;

  bfag_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quot),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_comb begin
    if (tiled) begin
      coord = PW'(div_rem);
    end else if (div_quot >= NW'(isz_sel)) begin
      coord = PW'(isz_sel - DW'(1));
    end else begin
      coord = PW'(div_quot);
    end
  end

  // raster advance after the current pixel
  assign x_inc   = DW'(cur_x) + DW'(1);
  assign y_inc   = DW'(cur_y) + DW'(1);
  assign last_px = (x_inc == cw) && (y_inc == ch);

  always_comb begin
    if (err) begin
      dest_x_next = '0;
      dest_y_next = '0;
    end else if (x_inc < cw) begin
      dest_x_next = PW'(x_inc);
      dest_y_next = cur_y;
    end else begin
      dest_x_next = '0;
      dest_y_next = (y_inc < ch) ? PW'(y_inc) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode     <= MODE_SOLID;
      fill_color    <= COLOR_RESET;
      canvas_width  <= '0;
      canvas_height <= '0;
      image_width   <= '0;
      image_height  <= '0;
      image_present <= 1'b0;
      dest_x        <= '0;
      dest_y        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (reg_idx_t'(cfg.index))
          REG_FILL_MODE:     fill_mode     <= cfg.data[MODE_W-1:0];
          REG_FILL_COLOR:    fill_color    <= cfg.data;
          REG_CANVAS_W:      canvas_width  <= cfg.data[CFG_DIM_W-1:0];
          REG_CANVAS_H:      canvas_height <= cfg.data[CFG_DIM_W-1:0];
          REG_IMAGE_W:       image_width   <= cfg.data[CFG_DIM_W-1:0];
          REG_IMAGE_H:       image_height  <= cfg.data[CFG_DIM_W-1:0];
          REG_IMAGE_PRESENT: image_present <= cfg.data[0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        dest_x    <= dest_x_next;
        dest_y    <= dest_y_next;
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      restart_q <= restart;
    end
    if (cmd.load) begin
      cur_x <= wrap ? '0 : dest_x;
      cur_y <= wrap ? '0 : dest_y;
      src_x <= '0;
      src_y <= '0;
    end
    if (cmd.capture) begin
      if (cmd.axis == AXIS_Y) begin
        src_y <= coord;
      end else begin
        src_x <= coord;
      end
    end
    if (cmd.addr) begin
      pix_prod <= NW'(cur_y) * NW'(cw);
      src_prod <= NW'(src_y) * NW'(iw);
    end
    if (cmd.commit) begin
      if (err) begin
        pixel.pixel_index  <= '0;
        pixel.source_index <= '0;
        pixel.use_fill     <= 1'b0;
        pixel.fill_value   <= '0;
        pixel.status       <= 1'b1;
        pixel.last         <= 1'b1;
      end else begin
        pixel.pixel_index  <= IDX_W'(pix_prod + NW'(cur_x));
        pixel.source_index <= fill ? '0 : IDX_W'(src_prod + NW'(src_x));
        pixel.use_fill     <= fill;
        pixel.fill_value   <= fill ? fill_val : '0;
        pixel.status       <= 1'b0;
        pixel.last         <= last_px;
      end
    end
  end

  assign pixel.valid = out_valid;

endmodule

`default_nettype wire

/* hw/rtl/background_fill_address_gen_core.sv */
// Background fill address generator.
// Walks a canvas in raster order and produces one output word per input word on
// the tick channel: destination pixel index plus either a fill color or the
// index of the source texel (tiled by modulo, or scaled nearest-neighbor).
// Channels: cfg (register index and data, always ready), tick (restart flag),
// pixel (result word). restart=1 starts the frame at pixel zero.
// One word is in flight at a time. After acceptance, error pixels pass the
// load and write states and fill pixels the load, address and write states.
// Image pixels also run two restoring divisions (x, then y) on one shared
// divider, one quotient bit per cycle, before the address and write states.
// After the write the controller returns to its idle state, where it takes
// the next word.
// The next tick word is taken while a finished result waits in the output
// register; a stalled receiver holds that register and, once the next word is
// done, blocks the block from taking another.
// Reset (synchronous, active high) returns registers to their defaults, the
// walk to pixel zero and drops any pending output word.
`default_nettype none

module background_fill_address_gen_core import bfag_pkg::*; #(
  parameter int MAX_DIM = 8192
) (
  input  logic          clk,
  input  logic          rst,
  bfag_cfg_if.sink      cfg,
  bfag_tick_if.sink     tick,
  bfag_pixel_if.source  pixel
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign tick.ready = in_ready;

  bfag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bfag_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (tick.restart),
    .cmd     (cmd),
    .sts     (sts),
    .pixel   (pixel)
  );

endmodule

`default_nettype wire

/* hw/rtl/bfag_chk.sv */
`default_nettype none

module bfag_chk import bfag_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               tick_valid,
  input logic               tick_ready,
  input logic               pix_valid,
  input logic               pix_ready,
  input logic [IDX_W-1:0]   pixel_index,
  input logic [IDX_W-1:0]   source_index,
  input logic               use_fill,
  input logic [COLOR_W-1:0] fill_value,
  input logic               status,
  input logic               last
);

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pixel_index) &&
      $stable(source_index) && $stable(fill_value) && $stable(status) && $stable(last))
    else $error("output word changed while stalled");

  // one word in flight: no back-to-back acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while a word is in flight");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    pix_valid && status |-> last && !use_fill && pixel_index == '0 &&
      source_index == '0 && fill_value == '0)
    else $error("error word not cleared");

  a_fill_word: assert property (@(posedge clk) disable iff (rst)
    pix_valid && use_fill |-> !status && source_index == '0)
    else $error("fill word carries a source index");

  a_copy_word: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !use_fill && !status |-> fill_value == '0)
    else $error("copy word carries a fill color");

endmodule

bind background_fill_address_gen_core bfag_chk u_bfag_chk (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .pix_valid    (pixel.valid),
  .pix_ready    (pixel.ready),
  .pixel_index  (pixel.pixel_index),
  .source_index (pixel.source_index),
  .use_fill     (pixel.use_fill),
  .fill_value   (pixel.fill_value),
  .status       (pixel.status),
  .last         (pixel.last)
);

`default_nettype wire
